>>> rtl/lfsr_starfield_overlay_macros.svh
// Assertion macros for the star field overlay checks
`ifndef LFSR_STARFIELD_OVERLAY_MACROS_SVH
`define LFSR_STARFIELD_OVERLAY_MACROS_SVH

// Check a property on every clock edge, reset included
`define LSO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on every clock edge outside reset
`define LSO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> rtl/lso_pkg.sv
// Shared types and constants of the star field overlay
package lso_pkg;

  localparam int COORD_BITS = 8;
  localparam int LFSR_W   = 16;
  localparam int DELAY_W  = 12;
  localparam int COLOR_W  = 3;
  localparam int X_STAR_BIT = 3;
  localparam int OUT_DATA_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  localparam logic [LFSR_W-1:0] LFSR_STAR_MASK  = 16'h80ff;
  localparam logic [LFSR_W-1:0] LFSR_STAR_MATCH = 16'h00ff;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 3'd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_STAR_ENABLE = 2'd0,
    CFG_STAR_DELAY  = 2'd1,
    CFG_FLIP_SCREEN = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               star;
  } result_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] r);
    logic fb;
    fb = ~r[15] ^ r[2];
    return {r[LFSR_W-2:0], fb};
  endfunction

  function automatic logic [COLOR_W-1:0] star_color(input logic [LFSR_W-1:0] r);
    return {r[12], r[10], r[8]};
  endfunction

endpackage

>>> rtl/lfsr_starfield_overlay.sv
// Star field overlay on a raster pixel stream, driven by a 16-bit shift register
// An accepted pixel's result is registered before it reaches the master side.
// Throughput: one pixel per cycle while the skid register is empty; a two-entry
// output buffer (result register plus skid register) keeps s_tready high while
// one result waits to be taken. Reset clears the shift register, the delay
// counter, all config registers and both buffer entries.
module lfsr_starfield_overlay import lso_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  input  logic [((2*COORD_BITS+COLOR_W+7)/8)*8-1:0] s_tdata,
  // frame_start
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // out_color, zero fill
  output logic [OUT_DATA_BITS-1:0]   m_tdata,
  // star_drawn
  output logic                       m_tuser
);

  logic                  star_enable;
  logic [DELAY_W-1:0]    star_delay;
  logic [LFSR_W-1:0]     star_lfsr;
  logic [LFSR_W-1:0]     star_lfsr_next;
  logic [DELAY_W-1:0]    delay_left;
  logic [DELAY_W-1:0]    delay_left_next;
  logic [DELAY_W-1:0]    delay_eff;

  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COLOR_W-1:0]    pixel_color;

  result_t               res;
  result_t               out_res;
  result_t               skid_res;
  logic                  out_valid;
  logic                  skid_valid;
  logic                  in_fire;
  logic                  out_free;

  assign pixel_x     = s_tdata[COORD_BITS-1:0];
  assign pixel_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign pixel_color = s_tdata[2*COORD_BITS+COLOR_W-1:2*COORD_BITS];

  assign s_tready = ~skid_valid;
  assign in_fire  = s_tvalid & s_tready;
  assign out_free = ~out_valid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      star_enable <= 1'b0;
      star_delay  <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_STAR_ENABLE: star_enable <= cfg_data[0];
        CFG_STAR_DELAY:  star_delay  <= cfg_data;
        CFG_FLIP_SCREEN: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    delay_eff = s_tuser ? star_delay : delay_left;

    res.star = star_enable && (pixel_color == COLOR_BLACK) &&
               ((star_lfsr & LFSR_STAR_MASK) == LFSR_STAR_MATCH) &&
               (pixel_y[0] ^ pixel_x[X_STAR_BIT]);
    res.color = res.star ? star_color(star_lfsr) : pixel_color;

    if (delay_eff == '0) begin
      star_lfsr_next  = lfsr_next(star_lfsr);
      delay_left_next = delay_eff;
    end else begin
      star_lfsr_next  = star_lfsr;
      delay_left_next = delay_eff - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      star_lfsr  <= '0;
      delay_left <= '0;
    end else if (in_fire) begin
      star_lfsr  <= star_lfsr_next;
      delay_left <= delay_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid | in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && in_fire) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_BITS-COLOR_W){1'b0}}, out_res.color};
  assign m_tuser  = out_res.star;

endmodule

>>> rtl/lso_checker.sv
// Port-level checks of the star field overlay, bound to the top level
`include "lfsr_starfield_overlay_macros.svh"

module lso_checker import lso_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic                     m_tuser
);

  `LSO_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")
  `LSO_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `LSO_ASSERT(a_no_invented, !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid, "result without request")
  `LSO_ASSERT(a_stall_only_full, !s_tready |-> m_tvalid, "input stalled with empty output")

endmodule

bind lfsr_starfield_overlay lso_checker u_lso_checker (.*);

>>> tb/sv/tb_lfsr_starfield_overlay.sv
`timescale 1ns / 100ps
// Self-checking testbench for the star field overlay: directed and random pixel streams
module tb_lfsr_starfield_overlay;
  import lso_pkg::*;

  localparam int PIXEL_W = ((2*COORD_BITS+COLOR_W+7)/8)*8;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic [PIXEL_W-1:0]        s_tdata = '0;
  logic                      s_tuser = 1'b0;
  logic                      m_tready = 1'b0;
  wire                       s_tready;
  wire                       m_tvalid;
  wire [OUT_DATA_BITS-1:0]   m_tdata;
  wire                       m_tuser;

  lfsr_starfield_overlay u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // overlay state as the block should hold it
  logic [LFSR_W-1:0]  star_reg = '0;
  logic [DELAY_W-1:0] hold_count = '0;
  logic               stars_on = 1'b0;
  logic [DELAY_W-1:0] hold_reload = '0;
  logic               flip_flag = 1'b0;

  result_t expected_pixels[$];
  logic    steady = 1'b0;
  int      error_count = 0;
  int      pixels_sent = 0;
  int      stars_seen = 0;
  int      dark_stars = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** lfsr_starfield_overlay: FAILED **");
    $finish;
  end

  function automatic result_t overlay_pixel(input logic fs, input logic [7:0] x,
                                            input logic [7:0] y,
                                            input logic [COLOR_W-1:0] col);
    result_t r;
    r.color = col;
    r.star = 1'b0;
    if (fs) hold_count = hold_reload;
    if (stars_on && col == COLOR_BLACK &&
        (star_reg & LFSR_STAR_MASK) == LFSR_STAR_MATCH &&
        (y[0] ^ x[X_STAR_BIT])) begin
      r.star = 1'b1;
      r.color = {star_reg[12], star_reg[10], star_reg[8]};
    end
    if (hold_count == 0) begin
      star_reg = {star_reg[LFSR_W-2:0], ~star_reg[LFSR_W-1] ^ star_reg[2]};
    end else begin
      hold_count = hold_count - 1'b1;
    end
    return r;
  endfunction

  task automatic send_pixel(input logic fs, input logic [7:0] x, input logic [7:0] y,
                            input logic [COLOR_W-1:0] col);
    result_t r;
    if (!steady && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fs;
    s_tdata <= PIXEL_W'({col, y, x});
    do @(posedge clk); while (!s_tready);
    r = overlay_pixel(fs, x, y, col);
    expected_pixels.push_back(r);
    pixels_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic en, input logic [DELAY_W-1:0] dly, input logic flip);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data <= junk;
    @(posedge clk);
    cfg_index <= CFG_STAR_ENABLE;
    cfg_data <= {junk[CFG_DATA_BITS-1:1], en};
    @(posedge clk);
    stars_on = en;
    cfg_index <= CFG_STAR_DELAY;
    cfg_data <= dly;
    @(posedge clk);
    hold_reload = dly;
    cfg_index <= CFG_FLIP_SCREEN;
    cfg_data <= {~junk[CFG_DATA_BITS-1:1], flip};
    @(posedge clk);
    flip_flag = flip;
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    logic [2:0] c;
    for (int i = 0; i < 8; i++) begin
      c = 3'(i);
      send_pixel(c == 3 || c == 6,
                 c[0] ? 8'hff : (c[2] ? 8'h08 : 8'h00),
                 c[1] ? 8'hff : (c[2] ? 8'h01 : 8'h00), c);
    end
    settle();
  endtask

  task automatic test_black_coordinates();
    write_regs(1'b1, 12'd3, 1'b1);
    send_pixel(1'b1, 8'h00, 8'h00, COLOR_BLACK);
    send_pixel(1'b0, 8'h08, 8'h00, COLOR_BLACK);
    send_pixel(1'b0, 8'h00, 8'h01, COLOR_BLACK);
    send_pixel(1'b0, 8'hff, 8'hff, COLOR_BLACK);
    send_pixel(1'b1, 8'hf7, 8'hfe, COLOR_BLACK);
    send_pixel(1'b0, 8'h08, 8'h01, 3'd7);
    send_pixel(1'b0, 8'h55, 8'haa, COLOR_BLACK);
    send_pixel(1'b0, 8'haa, 8'h55, 3'd4);
    settle();
  endtask

  // hold the register on a star pattern by reloading the delay when it comes up
  task automatic run_starfield(input int n, input logic en, input logic [DELAY_W-1:0] dly,
                               input logic flip, input int black_pct, input logic quiet);
    logic fs;
    logic hunt;
    logic [COLOR_W-1:0] col;
    write_regs(en, dly, flip);
    steady = quiet;
    for (int i = 0; i < n; i++) begin
      hunt = (star_reg & LFSR_STAR_MASK) == LFSR_STAR_MATCH && hold_count == 0;
      fs = hunt || $urandom_range(0, 99) < (hold_count != 0 ? 5 : 1);
      col = ($urandom_range(0, 99) < black_pct) ? COLOR_BLACK
                                                : COLOR_W'($urandom_range(1, 7));
      send_pixel(fs, 8'($urandom), 8'($urandom), col);
    end
    settle();
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual color %0d star %0b",
                 $time, m_tdata[COLOR_W-1:0], m_tuser);
      end else begin
        want = expected_pixels.pop_front();
        if (want.color != m_tdata[COLOR_W-1:0]) begin
          error_count++;
          $display("%0t: out_color mismatch: expected %0d, actual %0d",
                   $time, want.color, m_tdata[COLOR_W-1:0]);
        end
        if (want.star != m_tuser) begin
          error_count++;
          $display("%0t: star_drawn mismatch: expected %0b, actual %0b",
                   $time, want.star, m_tuser);
        end
        if (want.star) stars_seen++;
        if (want.star && want.color == COLOR_BLACK) dark_stars++;
      end
    end
    m_tready <= steady || $urandom_range(0, 99) >= 27;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_black_coordinates();
    run_starfield(200, 1'b1, 12'd0, 1'b0, 50, 1'b1);
    run_starfield(350, 1'b1, 12'd150, 1'b1, 70, 1'b0);
    run_starfield(200, 1'b1, 12'd1, 1'b0, 60, 1'b0);
    run_starfield(250, 1'b1, 12'd4095, 1'b1, 70, 1'b0);
    run_starfield(100, 1'b0, 12'd300, 1'b0, 70, 1'b0);
    $display("Sent %0d pixels over six register settings, delay 0 to 4095.", pixels_sent);
    $display("Stars drawn: %0d (%0d in color zero); mismatches: %0d.",
             stars_seen, dark_stars, error_count);
    if (error_count == 0) begin
      $display("** lfsr_starfield_overlay: PASSED **");
    end else begin
      $display("** lfsr_starfield_overlay: FAILED **");
    end
    $finish;
  end

endmodule
